// ===== hw/rtl/tcpq_pkg.sv =====
// shared types and codes for the three-class priority queue
`timescale 1ns / 1ps

package tcpq_pkg;

  localparam int DefaultCapacity = 64;
  localparam int ClassW    = 2;
  localparam int ClientW   = 16;
  localparam int DurationW = 16;
  localparam int StatusW   = 2;
  localparam int OccW      = 7;

  localparam logic [ClassW-1:0] ClassTop = 2'd2;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_kind_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef struct packed {
    logic [ClassW-1:0]    cls;
    logic [ClientW-1:0]   client;
    logic [DurationW-1:0] dur;
  } call_rec_t;

  typedef struct packed {
    logic ins;
    logic deq;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/three_class_priority_queue.sv =====
// top level of the three-class priority queue of call records
`timescale 1ns / 1ps

//  channel   direction  handshake              payload
//  request   in         req_valid / req_ready  req_type class_code client_id call_duration
//  result    out        res_valid / res_ready  status out_valid out_class out_client_id
//                                              out_duration occupancy
//
//  one request per cycle while req_ready is high; its result is registered and shows
//  in the cycle after acceptance; each chain cell loads straight from its neighbours
//  req_ready falls only while a result waits and res_ready is low
//  reset empties the queue through the fill count at once; there is no clearing pass
//  every request gives exactly one result

module three_class_priority_queue #(
  parameter int CAPACITY = tcpq_pkg::DefaultCapacity
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic                           req_type,
  input  logic [tcpq_pkg::ClassW-1:0]    class_code,
  input  logic [tcpq_pkg::ClientW-1:0]   client_id,
  input  logic [tcpq_pkg::DurationW-1:0] call_duration,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [tcpq_pkg::StatusW-1:0]   status,
  output logic                           out_valid,
  output logic [tcpq_pkg::ClassW-1:0]    out_class,
  output logic [tcpq_pkg::ClientW-1:0]   out_client_id,
  output logic [tcpq_pkg::DurationW-1:0] out_duration,
  output logic [tcpq_pkg::OccW-1:0]      occupancy
);
  import tcpq_pkg::*;

  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam logic [COUNT_W-1:0] CapCount = COUNT_W'(CAPACITY);

  logic                accept;
  logic                is_deq;
  logic                q_empty;
  logic                q_full;
  logic                do_deq;
  logic                do_ins;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  logic [COUNT_W+OccW-1:0] count_wide;
  call_rec_t           new_rec;
  cell_ctrl_t          ctrl;
  call_rec_t           recs  [CAPACITY];
  logic [CAPACITY-1:0] keeps;

  // request handshake: the result register frees up as its result is taken
  assign req_ready = !res_valid || res_ready;
  assign accept    = req_valid && req_ready;
  assign is_deq    = (req_type == REQ_DEQ);
  assign q_empty   = (count == '0);
  assign q_full    = (count == CapCount);
  assign do_deq    = accept && is_deq && !q_empty;
  assign do_ins    = accept && !is_deq && !q_full;

  // unused class code saturates to platinum
  assign new_rec.cls    = (class_code > ClassTop) ? ClassTop : class_code;
  assign new_rec.client = client_id;
  assign new_rec.dur    = call_duration;

  assign ctrl.ins = do_ins;
  assign ctrl.deq = do_deq;

  // fill count
  always_comb begin
    count_next = count;
    if (do_deq) begin
      count_next = count - COUNT_W'(1);
    end else if (do_ins) begin
      count_next = count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // chain of cells, slot 0 is the front of the queue
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    call_rec_t left_rec;
    call_rec_t right_rec;
    logic      left_keep;

    if (i == 0) begin : g_head
      assign left_rec  = new_rec;
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_rec  = recs[i-1];
      assign left_keep = keeps[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      // last slot falls out of the live range on dequeue
      assign right_rec = recs[i];
    end else begin : g_inner
      assign right_rec = recs[i+1];
    end

    tcpq_cell #(
      .IDX     (i),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk       (clk),
      .count     (count),
      .ctrl      (ctrl),
      .new_rec   (new_rec),
      .left_rec  (left_rec),
      .left_keep (left_keep),
      .right_rec (right_rec),
      .rec       (recs[i]),
      .keep      (keeps[i])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  assign count_wide = {{OccW{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (accept) begin
      out_valid     <= do_deq;
      out_class     <= do_deq ? recs[0].cls    : '0;
      out_client_id <= do_deq ? recs[0].client : '0;
      out_duration  <= do_deq ? recs[0].dur    : '0;
      // occupancy is the low bits of the count after this step
      occupancy     <= count_wide[OccW-1:0];
      if (is_deq && q_empty) begin
        status <= ST_EMPTY;
      end else if (!is_deq && q_full) begin
        status <= ST_DROPPED;
      end else begin
        status <= ST_OK;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CapCount)
    else $error("fill count beyond capacity");

  a_ins_grows : assert property (@(posedge clk) disable iff (rst)
    do_ins |=> count == $past(count) + COUNT_W'(1))
    else $error("enqueue did not grow the queue");

  a_empty_status : assert property (@(posedge clk) disable iff (rst)
    accept && is_deq && q_empty |=> res_valid && status == ST_EMPTY && !out_valid)
    else $error("dequeue on empty not reported");

  a_full_hold : assert property (@(posedge clk) disable iff (rst)
    accept && !is_deq && q_full |=> $stable(count) && status == ST_DROPPED)
    else $error("full queue changed on enqueue");

  for (genvar k = 1; k < CAPACITY; k++) begin : g_order_chk
    a_order : assert property (@(posedge clk) disable iff (rst)
      count > COUNT_W'(k) |-> recs[k-1].cls >= recs[k].cls)
      else $error("records out of class order");
  end
`endif

endmodule

// ===== hw/rtl/tcpq_cell.sv =====
// one slot of the sorted record chain
`timescale 1ns / 1ps

module tcpq_cell #(
  parameter int IDX     = 0,
  parameter int COUNT_W = 7
) (
  input  logic                clk,
  input  logic [COUNT_W-1:0]  count,
  input  tcpq_pkg::cell_ctrl_t ctrl,
  input  tcpq_pkg::call_rec_t new_rec,
  input  tcpq_pkg::call_rec_t left_rec,
  input  logic                left_keep,
  input  tcpq_pkg::call_rec_t right_rec,
  output tcpq_pkg::call_rec_t rec,
  output logic                keep
);
  import tcpq_pkg::*;

  logic occupied;

  // slots below the fill count hold live records
  assign occupied = (count > COUNT_W'(IDX));
  // live record of equal or higher class stays ahead of the new one
  assign keep = occupied && (rec.cls >= new_rec.cls);

  always_ff @(posedge clk) begin
    if (ctrl.deq) begin
      rec <= right_rec;
    end else if (ctrl.ins && !keep) begin
      rec <= left_keep ? new_rec : left_rec;
    end
  end

endmodule
